// ----- hdl/tqv_pkg.sv -----
// ----------------------------------------------------------------------------
// tqv_pkg
// Shared types and constants of the tile quad vertex generator.
// ----------------------------------------------------------------------------
package tqv_pkg;

   localparam int CFG_W  = 9;
   localparam int POS_W  = 18;
   localparam int TEX_W  = 29;
   localparam int BASE_W = 21;

   localparam logic [POS_W-1:0] POS_MAX = 18'h3FFFF;
   localparam int TEX_MAX = 268435455;

   // ceil(2^22 / 90), exact quotient for any 15-bit dividend
   localparam int RECIP_90 = 46604;
   localparam int RECIP_SHIFT = 22;

   localparam logic [1:0] CSR_TILE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_TILE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_TILES_PER_ROW = 2'd2;

   typedef struct packed {
      logic [11:0]       slot;
      logic [POS_W-1:0]  px_l;
      logic [POS_W-1:0]  px_r;
      logic [POS_W-1:0]  py_t;
      logic [POS_W-1:0]  py_b;
      logic [BASE_W-1:0] u_lo;
      logic [BASE_W-1:0] u_hi;
      logic [BASE_W-1:0] v_lo;
      logic [BASE_W-1:0] v_hi;
      logic [1:0]        turns;
      logic              flip;
   } tqv_tile_type;

endpackage

// ----- hdl/tile_quad_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// tile_quad_vertex_generator
// Turns one tile record into the four corner vertices of its quad: screen
// position from the grid and atlas coordinates from the tile index.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    slot, index, col, row, flip, rot
//   rsp      out        rsp_valid/stall    slot, corner, pos, tex, last
//   csr      in         csr_write          index, wdata
//
// A tile leaves as four corners through the output register, one corner per
// cycle while rsp is not stalled; an empty tile is dropped at the first stage.
// A request reaches its first corner through a 6-stage pipeline with a
// 4-stage index divider, a tile hold register and the output register.
// Reset is synchronous: valid bits clear and the size registers go to 16.
// A stall on rsp holds the pipeline stage by stage; nothing is dropped.
// ----------------------------------------------------------------------------
module tile_quad_vertex_generator #(
   parameter int INSET_Q8 = 26
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [11:0]                 req_tile_slot,
   input  logic signed [12:0]          req_tile_index,
   input  logic [9:0]                  req_grid_col,
   input  logic [9:0]                  req_grid_row,
   input  logic                        req_flip_horizontal,
   input  logic signed [15:0]          req_rot_degrees,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [11:0]                 rsp_quad_slot,
   output logic [1:0]                  rsp_corner,
   output logic [tqv_pkg::POS_W-1:0]   rsp_pos_x,
   output logic [tqv_pkg::POS_W-1:0]   rsp_pos_y,
   output logic signed [tqv_pkg::TEX_W-1:0] rsp_tex_u,
   output logic signed [tqv_pkg::TEX_W-1:0] rsp_tex_v,
   output logic                        rsp_last,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [tqv_pkg::CFG_W-1:0]   csr_wdata
);
   import tqv_pkg::*;

   localparam int NSTAGE = 6;
   localparam int MULW   = 31;

   typedef struct packed {
      logic [11:0]       slot;
      logic [11:0]       nq;
      logic [7:0]        rem;
      logic [9:0]        col;
      logic [9:0]        row;
      logic              flip;
      logic              rot_neg;
      logic [14:0]       rot;
      logic [1:0]        turns;
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
      logic [BASE_W-1:0] u_lo;
      logic [BASE_W-1:0] v_lo;
   } pipe_type;

   logic [CFG_W-1:0]  tw_ff;
   logic [CFG_W-1:0]  th_ff;
   logic [CFG_W-1:0]  tpr_ff;

   pipe_type          st_ff [NSTAGE];
   pipe_type          st_in [NSTAGE];
   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] adv;

   logic [MULW-1:0]   rot_prod;
   logic [POS_W-1:0]  px_prod;
   logic [POS_W-1:0]  py_prod;
   logic [BASE_W-1:0] tx_prod;
   logic [BASE_W-1:0] ty_prod;

   tqv_tile_type      tile;
   logic              emit_ready;

   function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return CFG_W'(1);
      end else if (v > CFG_W'(256)) begin
         return CFG_W'(256);
      end
      return v;
   endfunction

   function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] a,
                                                input logic [CFG_W-1:0] b);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + (POS_W+1)'(b);
      return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
   endfunction

   // three restoring division steps on the index
   function automatic pipe_type div3(input pipe_type p, input logic [CFG_W-1:0] d);
      pipe_type   r;
      logic [8:0] t;
      r = p;
      for (int j = 0; j < 3; j++) begin
         t = {r.rem, r.nq[11]};
         if (t >= d) begin
            t    = t - d;
            r.nq = {r.nq[10:0], 1'b1};
         end else begin
            r.nq = {r.nq[10:0], 1'b0};
         end
         r.rem = t[7:0];
      end
      return r;
   endfunction

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff  <= CFG_W'(16);
         th_ff  <= CFG_W'(16);
         tpr_ff <= CFG_W'(16);
      end else if (csr_write) begin
         case (csr_index)
            CSR_TILE_WIDTH:    tw_ff  <= clamp_reg(csr_wdata);
            CSR_TILE_HEIGHT:   th_ff  <= clamp_reg(csr_wdata);
            CSR_TILES_PER_ROW: tpr_ff <= clamp_reg(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // stage flow control
   always_comb begin
      adv[NSTAGE-1] = !v_ff[NSTAGE-1] || emit_ready;
      for (int i = NSTAGE-2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];

   assign rot_prod = MULW'(st_ff[0].rot) * MULW'(RECIP_90);
   assign px_prod  = POS_W'(st_ff[0].col) * POS_W'(tw_ff);
   assign py_prod  = POS_W'(st_ff[0].row) * POS_W'(th_ff);
   assign tx_prod  = BASE_W'(st_ff[4].rem) * BASE_W'(tw_ff);
   assign ty_prod  = BASE_W'(st_ff[4].nq) * BASE_W'(th_ff);

   always_comb begin
      st_in[0]         = '0;
      st_in[0].slot    = req_tile_slot;
      st_in[0].nq      = req_tile_index[11:0];
      st_in[0].rem     = 8'd0;
      st_in[0].col     = req_grid_col;
      st_in[0].row     = req_grid_row;
      st_in[0].flip    = req_flip_horizontal;
      st_in[0].rot_neg = req_rot_degrees[15];
      st_in[0].rot     = req_rot_degrees[14:0];

      for (int i = 1; i <= 4; i++) begin
         st_in[i] = div3(st_ff[i-1], tpr_ff);
      end
      st_in[1].turns = st_ff[0].rot_neg ? 2'd0 : rot_prod[RECIP_SHIFT+1:RECIP_SHIFT];
      st_in[1].px    = px_prod;
      st_in[1].py    = py_prod;

      st_in[5]      = st_ff[4];
      st_in[5].u_lo = tx_prod;
      st_in[5].v_lo = ty_prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid && !req_tile_index[12];
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // corner values of the finished tile
   always_comb begin
      tile.slot  = st_ff[NSTAGE-1].slot;
      tile.px_l  = st_ff[NSTAGE-1].px;
      tile.px_r  = sat_pos(st_ff[NSTAGE-1].px, tw_ff);
      tile.py_t  = st_ff[NSTAGE-1].py;
      tile.py_b  = sat_pos(st_ff[NSTAGE-1].py, th_ff);
      tile.u_lo  = st_ff[NSTAGE-1].u_lo;
      tile.u_hi  = st_ff[NSTAGE-1].u_lo + BASE_W'(tw_ff);
      tile.v_lo  = st_ff[NSTAGE-1].v_lo;
      tile.v_hi  = st_ff[NSTAGE-1].v_lo + BASE_W'(th_ff);
      tile.turns = st_ff[NSTAGE-1].turns;
      tile.flip  = st_ff[NSTAGE-1].flip;
   end

   tqv_corner_emit #(
      .INSET_Q8 (INSET_Q8)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (v_ff[NSTAGE-1]),
      .in_ready      (emit_ready),
      .in_tile       (tile),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_quad_slot (rsp_quad_slot),
      .rsp_corner    (rsp_corner),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_tex_u     (rsp_tex_u),
      .rsp_tex_v     (rsp_tex_v),
      .rsp_last      (rsp_last)
   );

   // input is held back only behind a full first stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v_ff[0])
      else $error("request stalled with empty first stage");

   // an empty tile never enters the pipeline
   a_empty_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_tile_index[12] |=> !v_ff[0])
      else $error("empty tile entered pipeline");

   // a blocked last stage keeps its tile
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[NSTAGE-1] && !adv[NSTAGE-1]
      |=> v_ff[NSTAGE-1] && $stable(st_ff[NSTAGE-1].slot)
          && $stable(st_ff[NSTAGE-1].u_lo))
      else $error("stalled tile lost in last stage");

endmodule

// ----- hdl/tqv_corner_emit.sv -----
// ----------------------------------------------------------------------------
// tqv_corner_emit
// Holds one finished tile and sends its four corners through an output register,
// one corner per cycle while rsp is not stalled, applying flip, rotation and inset.
// ----------------------------------------------------------------------------
module tqv_corner_emit #(
   parameter int INSET_Q8 = 26
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  tqv_pkg::tqv_tile_type       in_tile,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [11:0]                 rsp_quad_slot,
   output logic [1:0]                  rsp_corner,
   output logic [tqv_pkg::POS_W-1:0]   rsp_pos_x,
   output logic [tqv_pkg::POS_W-1:0]   rsp_pos_y,
   output logic signed [tqv_pkg::TEX_W-1:0] rsp_tex_u,
   output logic signed [tqv_pkg::TEX_W-1:0] rsp_tex_v,
   output logic                        rsp_last
);
   import tqv_pkg::*;

   localparam int QW = BASE_W + 10;
   localparam logic signed [QW-1:0] INSET_S = QW'(INSET_Q8);
   localparam logic signed [QW-1:0] TEX_MAX_S = QW'(TEX_MAX);

   tqv_tile_type      hold_ff;
   logic              hold_valid_ff;
   logic [1:0]        k_ff;

   logic              rsp_valid_ff;
   logic [11:0]       slot_ff;
   logic [1:0]        corner_ff;
   logic [POS_W-1:0]  pos_x_ff;
   logic [POS_W-1:0]  pos_y_ff;
   logic [TEX_W-1:0]  tex_u_ff;
   logic [TEX_W-1:0]  tex_v_ff;
   logic              last_ff;

   logic              out_load;
   logic              emit;
   logic [1:0]        s;
   logic              right;
   logic              bottom;
   logic [TEX_W-1:0]  tex_u_in;
   logic [TEX_W-1:0]  tex_v_in;

   function automatic logic [TEX_W-1:0] tex_field(input logic [BASE_W-1:0] base,
                                                  input logic high_side);
      logic signed [QW-1:0] q;
      q = $signed({2'b00, base, 8'h00});
      q = high_side ? (q - INSET_S) : (q + INSET_S);
      if (q > TEX_MAX_S) begin
         q = TEX_MAX_S;
      end
      return q[TEX_W-1:0];
   endfunction

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign emit     = out_load && hold_valid_ff;
   assign in_ready = !hold_valid_ff || (emit && (k_ff == 2'd3));

   always_comb begin
      s        = (k_ff - hold_ff.turns) ^ {1'b0, hold_ff.flip};
      right    = k_ff[0] ^ k_ff[1];
      bottom   = k_ff[1];
      tex_u_in = tex_field((s[0] ^ s[1]) ? hold_ff.u_hi : hold_ff.u_lo, right);
      tex_v_in = tex_field(s[1] ? hold_ff.v_hi : hold_ff.v_lo, bottom);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         k_ff          <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            hold_valid_ff <= in_valid;
         end
         if (emit) begin
            k_ff <= k_ff + 2'd1;
         end
         if (out_load) begin
            rsp_valid_ff <= hold_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         hold_ff <= in_tile;
      end
      if (emit) begin
         slot_ff   <= hold_ff.slot;
         corner_ff <= k_ff;
         pos_x_ff  <= right ? hold_ff.px_r : hold_ff.px_l;
         pos_y_ff  <= bottom ? hold_ff.py_b : hold_ff.py_t;
         tex_u_ff  <= tex_u_in;
         tex_v_ff  <= tex_v_in;
         last_ff   <= (k_ff == 2'd3);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quad_slot = slot_ff;
   assign rsp_corner    = corner_ff;
   assign rsp_pos_x     = pos_x_ff;
   assign rsp_pos_y     = pos_y_ff;
   assign rsp_tex_u     = tex_u_ff;
   assign rsp_tex_v     = tex_v_ff;
   assign rsp_last      = last_ff;

   // corners of one tile follow each other without a gap
   a_corner_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last
      |=> rsp_valid && (rsp_corner == $past(rsp_corner) + 2'd1))
      else $error("corner sequence broken");

   // a new tile always starts at the top-left corner
   a_corner_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid || (rsp_corner == 2'd0))
      else $error("tile does not start at corner zero");

   // a stalled corner stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall
      |=> rsp_valid && $stable(rsp_corner) && $stable(rsp_tex_u) && $stable(rsp_pos_x))
      else $error("stalled corner changed");

endmodule

// ----- dv/tb_tile_quad_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// tb_tile_quad_vertex_generator
// Self-checking bench for the tile quad vertex generator. Tile requests go in
// with random gaps, and the corner results leave under random stalls, except
// in two steady phases with neither. A scoreboard predicts the four corners of
// each accepted non-empty request from its own copy of the size registers and
// checks every corner field by field. Phases at several register settings, the
// extremes among them, run between idle points. The settings include clamped
// sizes and saturating positions and texture coordinates.
// ----------------------------------------------------------------------------
module tb_tile_quad_vertex_generator;
   import tqv_pkg::*;

   localparam int INSET_Q8     = 26;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_TILES  = 50;

   typedef struct packed {
      logic [11:0] slot;
      logic [12:0] index;
      logic [9:0]  col;
      logic [9:0]  row;
      logic        flip;
      logic [15:0] rot;
   } tile_req_type;

   typedef struct packed {
      logic [11:0]      slot;
      logic [1:0]       corner;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic             last;
   } corner_type;

   class quad_scoreboard;
      logic [CFG_W-1:0] tile_w = CFG_W'(16);
      logic [CFG_W-1:0] tile_h = CFG_W'(16);
      logic [CFG_W-1:0] per_row = CFG_W'(16);
      corner_type pending_corners[$];
      int mismatches = 0;

      function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_TILE_WIDTH: tile_w = val;
            CSR_TILE_HEIGHT: tile_h = val;
            CSR_TILES_PER_ROW: per_row = val;
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > 256) return 256;
         return int'(v);
      endfunction

      function logic [POS_W-1:0] sat_pos(int unsigned v);
         if (v > int'(POS_MAX)) return POS_MAX;
         return v[POS_W-1:0];
      endfunction

      function logic [TEX_W-1:0] tex_q8(int unsigned px, bit high_side);
         longint q;
         q = longint'(px) * 256 + (high_side ? -INSET_Q8 : INSET_Q8);
         if (q > TEX_MAX) q = TEX_MAX;
         return q[TEX_W-1:0];
      endfunction

      function void note_tile(tile_req_type t);
         int unsigned tw, th, tpr, idx, turns, tx, ty, px, py, s, u, v;
         bit right, bottom;
         corner_type c;
         tw = clamp_size(tile_w);
         th = clamp_size(tile_h);
         tpr = clamp_size(per_row);
         // negative index marks an empty tile
         if (t.index[12]) return;
         idx = t.index[11:0];
         turns = t.rot[15] ? 0 : (int'(t.rot[14:0]) / 90) % 4;
         tx = (idx % tpr) * tw;
         ty = (idx / tpr) * th;
         px = t.col * tw;
         py = t.row * th;
         for (int k = 0; k < 4; k++) begin
            s = (k + 4 - turns) % 4;
            if (t.flip) s = s ^ 1;
            right = (k == 1 || k == 2);
            bottom = (k >= 2);
            u = tx + ((s == 1 || s == 2) ? tw : 0);
            v = ty + ((s >= 2) ? th : 0);
            c.slot = t.slot;
            c.corner = k[1:0];
            c.pos_x = sat_pos(px + (right ? tw : 0));
            c.pos_y = sat_pos(py + (bottom ? th : 0));
            c.tex_u = tex_q8(u, right);
            c.tex_v = tex_q8(v, bottom);
            c.last = (k == 3);
            pending_corners = {pending_corners, c};
         end
      endfunction

      function int outstanding();
         return pending_corners.size();
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task check_corner(corner_type got);
         corner_type want;
         if (pending_corners.size() == 0) begin
            report_mismatch($sformatf("corner with no request pending, slot %0d corner %0d",
                                      got.slot, got.corner));
            return;
         end
         want = pending_corners.pop_front();
         if (got.slot !== want.slot)
            report_mismatch($sformatf("quad_slot got %0d want %0d", got.slot, want.slot));
         if (got.corner !== want.corner)
            report_mismatch($sformatf("slot %0d corner got %0d want %0d",
                                      want.slot, got.corner, want.corner));
         if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("slot %0d corner %0d pos_x got %0d want %0d",
                                      want.slot, want.corner, got.pos_x, want.pos_x));
         if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("slot %0d corner %0d pos_y got %0d want %0d",
                                      want.slot, want.corner, got.pos_y, want.pos_y));
         if (got.tex_u !== want.tex_u)
            report_mismatch($sformatf("slot %0d corner %0d tex_u got %0d want %0d", want.slot,
                                      want.corner, $signed(got.tex_u), $signed(want.tex_u)));
         if (got.tex_v !== want.tex_v)
            report_mismatch($sformatf("slot %0d corner %0d tex_v got %0d want %0d", want.slot,
                                      want.corner, $signed(got.tex_v), $signed(want.tex_v)));
         if (got.last !== want.last)
            report_mismatch($sformatf("slot %0d corner %0d last got %0b want %0b",
                                      want.slot, want.corner, got.last, want.last));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [11:0]               req_tile_slot = '0;
   logic signed [12:0]        req_tile_index = '0;
   logic [9:0]                req_grid_col = '0;
   logic [9:0]                req_grid_row = '0;
   logic                      req_flip_horizontal = 1'b0;
   logic signed [15:0]        req_rot_degrees = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [11:0]               rsp_quad_slot;
   logic [1:0]                rsp_corner;
   logic [POS_W-1:0]          rsp_pos_x;
   logic [POS_W-1:0]          rsp_pos_y;
   logic signed [TEX_W-1:0]   rsp_tex_u;
   logic signed [TEX_W-1:0]   rsp_tex_v;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic [1:0]                csr_index = CSR_TILE_WIDTH;
   logic [CFG_W-1:0]          csr_wdata = '0;

   quad_scoreboard sb = new;
   bit           steady = 1'b0;
   int           stall_left = 0;
   int           flow_left = 0;
   int           cycle_count = 0;
   tile_req_type seen_tile;
   corner_type   seen_corner;

   tile_quad_vertex_generator #(.INSET_Q8(INSET_Q8)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_tile_slot(req_tile_slot),
      .req_tile_index(req_tile_index),
      .req_grid_col(req_grid_col),
      .req_grid_row(req_grid_row),
      .req_flip_horizontal(req_flip_horizontal),
      .req_rot_degrees(req_rot_degrees),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_quad_slot(rsp_quad_slot),
      .rsp_corner(rsp_corner),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_tex_u(rsp_tex_u),
      .rsp_tex_v(rsp_tex_v),
      .rsp_last(rsp_last),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 48);
   endfunction

   function automatic tile_req_type tile_of(int slot, int index, int col, int row, int flip,
                                            int rot);
      tile_req_type t;
      t.slot = slot[11:0];
      t.index = index[12:0];
      t.col = col[9:0];
      t.row = row[9:0];
      t.flip = flip[0];
      t.rot = rot[15:0];
      return t;
   endfunction

   function automatic tile_req_type rand_tile();
      tile_req_type t;
      t.slot = 12'($urandom);
      t.index = ($urandom_range(0, 9) == 0) ? {1'b1, 12'($urandom)}
                                             : {1'b0, 12'($urandom_range(0, 4095))};
      t.col = 10'($urandom);
      t.row = 10'($urandom);
      t.flip = 1'($urandom);
      if ($urandom_range(0, 1) == 0)
         t.rot = 16'($urandom);
      else
         t.rot = 16'(90 * $urandom_range(0, 363) + $urandom_range(0, 89));
      return t;
   endfunction

   function automatic int rand_size();
      case ($urandom_range(0, 9))
         0: return int'(CFG_W'($urandom));
         1: return 256;
         default: return int'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic drive_tile(input tile_req_type t);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tile_slot <= t.slot;
      req_tile_index <= t.index;
      req_grid_col <= t.col;
      req_grid_row <= t.row;
      req_flip_horizontal <= t.flip;
      req_rot_degrees <= t.rot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input int w, input int h, input int n);
      csr_write <= 1'b1;
      csr_index <= CSR_TILE_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      csr_index <= CSR_TILE_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      csr_index <= CSR_TILES_PER_ROW;
      csr_wdata <= CFG_W'(n);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // request, result and register monitors
   always @(posedge clock) begin
      if (!reset && csr_write) sb.write_reg(csr_index, csr_wdata);
      if (!reset && req_valid && !req_stall) begin
         seen_tile.slot = req_tile_slot;
         seen_tile.index = req_tile_index;
         seen_tile.col = req_grid_col;
         seen_tile.row = req_grid_row;
         seen_tile.flip = req_flip_horizontal;
         seen_tile.rot = req_rot_degrees;
         sb.note_tile(seen_tile);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_corner.slot = rsp_quad_slot;
         seen_corner.corner = rsp_corner;
         seen_corner.pos_x = rsp_pos_x;
         seen_corner.pos_y = rsp_pos_y;
         seen_corner.tex_u = rsp_tex_u;
         seen_corner.tex_v = rsp_tex_v;
         seen_corner.last = rsp_last;
         sb.check_corner(seen_corner);
      end
   end

   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (flow_left > 0) begin
         flow_left--;
         rsp_stall <= 1'b0;
      end else begin
         flow_left = $urandom_range(0, 10);
         stall_left = idle_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tile_quad_vertex_generator verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: corner order, rotations, flips, empty tiles
      drive_tile(tile_of(0, 0, 0, 0, 0, 0));
      drive_tile(tile_of(4095, 4095, 1023, 1023, 1, 32767));
      drive_tile(tile_of(1, -1, 5, 5, 0, 0));
      drive_tile(tile_of(2, -4096, 7, 7, 1, 90));
      drive_tile(tile_of(3, 17, 2, 3, 0, 90));
      drive_tile(tile_of(4, 18, 2, 3, 0, 180));
      drive_tile(tile_of(5, 19, 2, 3, 0, 270));
      drive_tile(tile_of(6, 20, 2, 3, 0, 360));
      drive_tile(tile_of(7, 21, 2, 3, 1, -90));
      drive_tile(tile_of(8, 22, 2, 3, 1, -32768));
      drive_tile(tile_of(9, 23, 4, 4, 0, 89));
      drive_tile(tile_of(10, 255, 9, 9, 1, 359));
      drive_tile(tile_of(11, 256, 0, 1, 1, 0));
      drive_tile(tile_of(12, 100, 1, 0, 1, 270));

      for (int p = 0; p < 7; p++) begin
         wait_idle();
         case (p)
            0: write_config(1, 1, 1);
            1: write_config(256, 256, 256);
            2: write_config(0, 511, 0);
            3: write_config(256, 256, 1);
            default: write_config(rand_size(), rand_size(), rand_size());
         endcase
         steady = (p == 2 || p == 5);
         if (p == 3) begin
            // position and texture saturation
            drive_tile(tile_of(100, 4095, 1023, 1023, 0, 0));
            drive_tile(tile_of(101, 4095, 1023, 1023, 1, 0));
            drive_tile(tile_of(102, 4095, 1023, 0, 0, 180));
            drive_tile(tile_of(103, 0, 0, 1023, 1, 90));
         end
         repeat (PHASE_TILES) drive_tile(rand_tile());
      end
      wait_idle();

      if (sb.mismatches == 0)
         $display("tile_quad_vertex_generator verification clean");
      else
         $display("tile_quad_vertex_generator verification failed");
      $finish;
   end

endmodule
